FILE: hdl/shrink_conditional_mark_top_defines.svh
// Assertion macros for the conditional shrink mark block.
// Used by the checker bound to shrink_conditional_mark_top; no other dependencies.
`ifndef SHRINK_CONDITIONAL_MARK_TOP_DEFINES_SVH
`define SHRINK_CONDITIONAL_MARK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shrink mark check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shrink mark check failed");

`endif

FILE: hdl/scm_pkg.sv
// Shared types, constants and the pattern match function of the shrink mark block.
// No dependencies; used by the pixel and cfg interfaces, the top level and the testbench.
package scm_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int PIXEL_W       = 8;
    localparam int WIDTH_REG_W   = 11;
    localparam int HEIGHT_REG_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int ROW_W         = 12;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int PATTERN_COUNT = 58;

    localparam logic [PIXEL_W-1:0]      PIXEL_FG     = 8'hFF;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd256;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd256;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Bond in bits 12:9, window pattern (top-left at bit 8) in bits 8:0.
    localparam logic [12:0] SHRINK_TABLE [PATTERN_COUNT] = '{
        {4'd1, 9'o120}, {4'd1, 9'o420}, {4'd1, 9'o024}, {4'd1, 9'o021},
        {4'd2, 9'o030}, {4'd2, 9'o220}, {4'd2, 9'o060}, {4'd2, 9'o022},
        {4'd3, 9'o130}, {4'd3, 9'o320}, {4'd3, 9'o620}, {4'd3, 9'o460},
        {4'd3, 9'o064}, {4'd3, 9'o026}, {4'd3, 9'o023}, {4'd3, 9'o031},
        {4'd4, 9'o131}, {4'd4, 9'o720}, {4'd4, 9'o464}, {4'd4, 9'o027},
        {4'd5, 9'o630}, {4'd5, 9'o231}, {4'd5, 9'o360}, {4'd5, 9'o132},
        {4'd5, 9'o330}, {4'd5, 9'o660}, {4'd5, 9'o066}, {4'd5, 9'o033},
        {4'd6, 9'o631}, {4'd6, 9'o364}, {4'd6, 9'o730}, {4'd6, 9'o331},
        {4'd6, 9'o760}, {4'd6, 9'o664}, {4'd6, 9'o466}, {4'd6, 9'o067},
        {4'd6, 9'o037}, {4'd6, 9'o133},
        {4'd7, 9'o731}, {4'd7, 9'o764}, {4'd7, 9'o467}, {4'd7, 9'o137},
        {4'd8, 9'o333}, {4'd8, 9'o770}, {4'd8, 9'o666}, {4'd8, 9'o077},
        {4'd9, 9'o733}, {4'd9, 9'o337}, {4'd9, 9'o774}, {4'd9, 9'o771},
        {4'd9, 9'o766}, {4'd9, 9'o667}, {4'd9, 9'o477}, {4'd9, 9'o177},
        {4'd10, 9'o737}, {4'd10, 9'o775}, {4'd10, 9'o767}, {4'd10, 9'o577}
    };

    // Corners weigh 1, edge neighbors weigh 2.
    function automatic logic [3:0] bond_of(input logic [8:0] w);
        logic [3:0] corners;
        logic [3:0] edges;
        corners = 4'(w[8]) + 4'(w[6]) + 4'(w[2]) + 4'(w[0]);
        edges   = 4'(w[7]) + 4'(w[5]) + 4'(w[3]) + 4'(w[1]);
        return corners + {edges[2:0], 1'b0};
    endfunction

    // Bonds 0, 11 and 12 have no entry in the table, so they never match.
    function automatic logic shrink_mark(input logic [8:0] w);
        logic [3:0] bond;
        logic       hit;
        bond = bond_of(w);
        hit  = 1'b0;
        for (int i = 0; i < PATTERN_COUNT; i++)
        begin
            if (SHRINK_TABLE[i][12:9] == bond && SHRINK_TABLE[i][8:0] == w)
            begin
                hit = 1'b1;
            end
        end
        return w[4] & hit;
    endfunction

endpackage

FILE: hdl/scm_pixel_if.sv
// Pixel input channel: valid/ready handshake with one 8-bit pixel.
// Depends on scm_pkg for the pixel width.
interface scm_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [scm_pkg::PIXEL_W-1:0]   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

FILE: hdl/scm_result_if.sv
// Result channel: valid/ready handshake with the mark bit and the frame-end flag.
// No package dependencies.
interface scm_result_if;
    logic valid;
    logic ready;
    logic mark;
    logic last_of_frame;

    modport source (output valid, output mark, output last_of_frame, input ready);
    modport sink   (input valid, input mark, input last_of_frame, output ready);
endinterface

FILE: hdl/scm_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on scm_pkg for the register index type and data width.
interface scm_cfg_if;
    logic                            valid;
    logic                            ready;
    scm_pkg::cfg_reg_t               index;
    logic [scm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/shrink_conditional_mark_top.sv
// Conditional shrink mark: pixel stream in, one mark per interior pixel out.
// Channels: cfg writes image_width (index 0) and image_height (index 1); it is
// always ready and must only be used while no pixel results are outstanding.
// pix carries one 8-bit pixel per transfer in row-major order; 255 is foreground.
// res carries mark and last_of_frame for each interior center (row and column
// of the incoming pixel both >= 2), referring to the pixel one row up and one
// column left; last_of_frame flags the final result of the frame.
// Throughput: one pixel per cycle while the result queue has room. The line store
// is a RAM read in advance at the next column, so the window, bond and pattern
// match finish in the cycle the pixel is taken; the result is registered in the queue.
// A two-entry result queue decouples the sides: pixels keep flowing while a
// result waits, and pix.ready drops only when both entries are occupied.
// Reset: counters, window and queue clear; width and height return to 256.
// The line store is not cleared: entries are always written in a frame's
// first rows before any emitted window reads them.
module shrink_conditional_mark_top #(
    parameter int MAX_WIDTH = scm_pkg::MAX_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    scm_cfg_if.sink            cfg,
    scm_pixel_if.sink          pix,
    scm_result_if.source       res
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);
    localparam int HW = scm_pkg::HEIGHT_REG_W;
    localparam int RW = scm_pkg::ROW_W;

    logic [scm_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [scm_pkg::HEIGHT_REG_W-1:0] image_height_reg;
    logic [CW-1:0]                    col_reg;
    logic [CW-1:0]                    col_next;
    logic [RW-1:0]                    row_reg;
    logic [RW-1:0]                    row_next;
    logic [8:0]                       window_reg;
    logic [8:0]                       window_next;
    logic [EW-1:0]                    eff_width;
    logic [HW-1:0]                    eff_height;
    logic [1:0]                       store_rd;
    logic [1:0]                       store_wr;
    logic                             fg;
    logic                             accept;
    logic                             emit;
    logic                             row_end;
    logic                             frame_end;
    logic                             last_flag;
    logic                             push;
    logic                             pop;

    logic [1:0]                       q_data_reg [2];
    logic                             q_wr_ptr_reg;
    logic                             q_rd_ptr_reg;
    logic [1:0]                       q_count_reg;
    logic [1:0]                       q_count_next;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= scm_pkg::WIDTH_RESET;
            image_height_reg <= scm_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                scm_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg.data[scm_pkg::WIDTH_REG_W-1:0];
                end
                scm_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Saturate the frame size to its legal range
    always_comb
    begin
        if (32'(image_width_reg) < 32'd3)
        begin
            eff_width = EW'(3);
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_width = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = EW'(image_width_reg);
        end

        if (image_height_reg < HW'(3))
        begin
            eff_height = HW'(3);
        end
        else if (32'(image_height_reg) > 32'(scm_pkg::HEIGHT_LIMIT))
        begin
            eff_height = HW'(scm_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            eff_height = image_height_reg;
        end
    end

    // Position tracking and window update
    assign pix.ready = (q_count_reg != 2'd2);
    assign accept    = pix.valid & pix.ready;
    assign fg        = (pix.pixel == scm_pkg::PIXEL_FG);

    assign row_end   = (32'(col_reg) + 32'd1 >= 32'(eff_width));
    assign frame_end = (32'(row_reg) + 32'd1 >= 32'(eff_height));

    assign emit = (row_reg >= RW'(2)) && (col_reg >= CW'(2))
                  && (32'(row_reg) < 32'(eff_height)) && (32'(col_reg) < 32'(eff_width));
    assign last_flag = (32'(row_reg) + 32'd1 == 32'(eff_height))
                       && (32'(col_reg) + 32'd1 == 32'(eff_width));

    assign window_next = ((window_reg << 1) & 9'o666)
                         | {2'b00, store_rd[1], 2'b00, store_rd[0], 2'b00, fg};
    assign store_wr    = {store_rd[0], fg};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            window_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept)
            begin
                window_reg <= window_next;
            end
        end
    end

    // Line store: read the column of the next pixel in advance. The write
    // goes to the current column, which never equals the next one (width >= 3).
    scm_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (store_wr),
        .rd_addr (col_next),
        .rd_data (store_rd)
    );

    // Two-entry result queue
    assign push = accept & emit;
    assign pop  = res.valid & res.ready;

    always_comb
    begin
        q_count_next = q_count_reg;
        if (push && !pop)
        begin
            q_count_next = q_count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            q_count_next = q_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_count_reg  <= 2'd0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (push)
            begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (pop)
            begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[q_wr_ptr_reg] <= {scm_pkg::shrink_mark(window_next), last_flag};
        end
    end

    assign res.valid         = (q_count_reg != 2'd0);
    assign res.mark          = q_data_reg[q_rd_ptr_reg][1];
    assign res.last_of_frame = q_data_reg[q_rd_ptr_reg][0];

endmodule

FILE: hdl/scm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scm_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hdl/scm_checker.sv
// Port-level checker for shrink_conditional_mark_top, attached by bind.
// Depends on shrink_conditional_mark_top_defines.svh for the assertion macros.
`include "shrink_conditional_mark_top_defines.svh"

module scm_checker (
    input logic clk,
    input logic rst_n,
    input logic pix_valid,
    input logic pix_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_mark,
    input logic res_last_of_frame
);

    // A held result keeps its payload until transferred
    `SCM_ASSERT_NXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_mark) && $stable(res_last_of_frame))

    // Results only appear after a pixel transfer
    `SCM_ASSERT_NOW(a_res_cause, clk, rst_n, $rose(res_valid), $past(pix_valid && pix_ready))

    // Input backpressure only while results are pending
    `SCM_ASSERT_NOW(a_stall_cause, clk, rst_n, pix_valid && !pix_ready, res_valid)

    // With the output draining freely the input never stalls
    `SCM_ASSERT_NXT(a_no_stall, clk, rst_n, !res_valid || res_ready, pix_ready)

endmodule

bind shrink_conditional_mark_top scm_checker u_scm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .pix_valid         (pix.valid),
    .pix_ready         (pix.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_mark          (res.mark),
    .res_last_of_frame (res.last_of_frame)
);

FILE: dv/tb.sv
// Testbench for shrink_conditional_mark_top: drives pixel frames and register writes,
// predicts every interior mark and frame-end flag, and checks each result transfer.
// Depends on scm_pkg and the scm_pixel_if, scm_result_if and scm_cfg_if interfaces.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LINE_DEPTH   = 1024;
    localparam int         HEIGHT_CAP   = 4096;
    localparam logic [7:0] FG_LEVEL     = 8'd255;

    typedef struct packed
    {
        logic mark;
        logic frame_end;
    } mark_result_t;

    logic clk = 1'b0;
    logic rst_n;

    scm_pixel_if  pix_if ();
    scm_result_if res_if ();
    scm_cfg_if    cfg_if ();

    shrink_conditional_mark_top uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .pix   (pix_if),
        .res   (res_if)
    );

    always #5 clk = ~clk;

    // Mark model state
    logic [10:0]  width_reg  = 11'd256;
    logic [12:0]  height_reg = 13'd256;
    logic [1:0]   line_mem [LINE_DEPTH] = '{default: 2'b00};
    logic [8:0]   win_bits   = 9'd0;
    logic [9:0]   col_q      = 10'd0;
    logic [11:0]  row_q      = 12'd0;

    mark_result_t expected_marks [$];
    mark_result_t got_mark;
    int           error_count   = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = height_reg;
        if (h < 3) h = 3;
        if (h > HEIGHT_CAP) h = HEIGHT_CAP;
        return h;
    endfunction

    // Conditional shrink pattern lookup, grouped by bond.
    function automatic logic pattern_hit(input logic [8:0] w);
        int unsigned bond;
        logic        hit;
        if (!w[4])
            return 1'b0;
        bond = w[8] + w[6] + w[2] + w[0] + 2 * (w[7] + w[5] + w[3] + w[1]);
        case (w)
            9'o120, 9'o420, 9'o024, 9'o021:
                hit = (bond == 1);
            9'o030, 9'o220, 9'o060, 9'o022:
                hit = (bond == 2);
            9'o130, 9'o320, 9'o620, 9'o460, 9'o064, 9'o026, 9'o023, 9'o031:
                hit = (bond == 3);
            9'o131, 9'o720, 9'o464, 9'o027:
                hit = (bond == 4);
            9'o630, 9'o231, 9'o360, 9'o132, 9'o330, 9'o660, 9'o066, 9'o033:
                hit = (bond == 5);
            9'o631, 9'o364, 9'o730, 9'o331, 9'o760, 9'o664, 9'o466, 9'o067,
            9'o037, 9'o133:
                hit = (bond == 6);
            9'o731, 9'o764, 9'o467, 9'o137:
                hit = (bond == 7);
            9'o333, 9'o770, 9'o666, 9'o077:
                hit = (bond == 8);
            9'o733, 9'o337, 9'o774, 9'o771, 9'o766, 9'o667, 9'o477, 9'o177:
                hit = (bond == 9);
            9'o737, 9'o775, 9'o767, 9'o577:
                hit = (bond == 10);
            default:
                hit = 1'b0;
        endcase
        return hit;
    endfunction

    task automatic step_mark_model(input logic [7:0] value);
        int unsigned  w;
        int unsigned  h;
        int unsigned  col;
        int unsigned  row;
        logic         fg;
        logic [1:0]   st;
        mark_result_t r;
        w   = active_width();
        h   = active_height();
        col = col_q;
        row = row_q;
        fg  = (value == FG_LEVEL);
        st  = line_mem[col];
        win_bits = {win_bits[7:6], st[1], win_bits[4:3], st[0], win_bits[1:0], fg};
        line_mem[col] = {st[0], fg};
        if (row >= 2 && col >= 2 && row < h && col < w)
        begin
            r.mark      = pattern_hit(win_bits);
            r.frame_end = (row == h - 1) && (col == w - 1);
            expected_marks.push_back(r);
        end
        // Wrap on the row end, also when a smaller size left the counter past it.
        if (col + 1 >= w)
        begin
            col_q = 10'd0;
            row_q = (row + 1 >= h) ? 12'd0 : 12'(row + 1);
        end
        else
        begin
            col_q = 10'(col + 1);
        end
    endtask

    task automatic send_pixel(input logic [7:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        do @(posedge clk); while (!pix_if.ready);
        step_mark_model(value);
    endtask

    function automatic logic [7:0] random_pixel(input int fg_pct);
        if ($urandom_range(0, 99) < fg_pct)
            return FG_LEVEL;
        return 8'($urandom_range(0, 254));
    endfunction

    // Hold off pixels until every pending mark has come back.
    task automatic drain_marks();
        pix_if.valid <= 1'b0;
        while (expected_marks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input scm_pkg::cfg_reg_t idx, input logic [12:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        if (idx == scm_pkg::REG_IMAGE_WIDTH)
            width_reg = value[10:0];
        else
            height_reg = value;
    endtask

    task automatic set_size(input logic do_width, input logic [12:0] width_val,
                            input logic do_height, input logic [12:0] height_val);
        drain_marks();
        if (do_width)
            write_reg(scm_pkg::REG_IMAGE_WIDTH, width_val);
        if (do_height)
            write_reg(scm_pkg::REG_IMAGE_HEIGHT, height_val);
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_marks.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual mark=%b last=%b",
                         $realtime, res_if.mark, res_if.last_of_frame);
                error_count++;
            end
            else
            begin
                got_mark = expected_marks.pop_front();
                if (res_if.mark !== got_mark.mark)
                begin
                    $display("%0t: mark mismatch: expected %b, actual %b",
                             $realtime, got_mark.mark, res_if.mark);
                    error_count++;
                end
                if (res_if.last_of_frame !== got_mark.frame_end)
                begin
                    $display("%0t: last_of_frame mismatch: expected %b, actual %b",
                             $realtime, got_mark.frame_end, res_if.last_of_frame);
                    error_count++;
                end
            end
        end
        res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Write every line store column that the later tests reach, three rows deep.
    task automatic test_line_fill();
        set_size(1'b1, 13'd12, 1'b1, 13'd3);
        repeat (36) send_pixel(random_pixel(50));
    endtask

    // Three-wide column of rows: each new row slides one window down.
    task automatic test_window_cases();
        logic [2:0]  rows [10];
        logic [7:0]  bg_levels [5];
        int          k;
        rows      = '{3'o0, 3'o2, 3'o0, 3'o7, 3'o7, 3'o7, 3'o3, 3'o5, 3'o2, 3'o5};
        bg_levels = '{8'd0, 8'd254, 8'd127, 8'd128, 8'd1};
        k = 0;
        set_size(1'b1, 13'd3, 1'b1, 13'd10);
        foreach (rows[r])
        begin
            for (int c = 2; c >= 0; c--)
            begin
                send_pixel(rows[r][c] ? FG_LEVEL : bg_levels[k % 5]);
                k++;
            end
        end
    endtask

    task automatic test_size_saturation();
        set_size(1'b1, 13'd0, 1'b1, 13'd1);
        repeat (18) send_pixel(random_pixel(60));
        set_size(1'b1, 13'd2, 1'b1, 13'h1FFF);
        repeat (18) send_pixel(random_pixel(60));
        set_size(1'b1, 13'd1, 1'b1, 13'd0);
        repeat (9) send_pixel(random_pixel(60));
    endtask

    task automatic test_counter_wrap();
        set_size(1'b1, 13'd5, 1'b1, 13'd6);
        repeat (13) send_pixel(random_pixel(50));
        // Column now past the new width: the next pixel ends the row.
        set_size(1'b1, 13'd3, 1'b0, 13'd0);
        repeat (7) send_pixel(random_pixel(50));
        // Row now past the new height: the end of this row ends the frame.
        set_size(1'b0, 13'd0, 1'b1, 13'd4);
        repeat (15) send_pixel(random_pixel(50));
    endtask

    task automatic test_random_frames(input int send_pct, input int recv_pct,
                                      input int item_count);
        int         sent;
        int         seg_len;
        int         density;
        int         pick;
        logic [12:0] w_val;
        logic [12:0] h_val;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < item_count)
        begin
            w_val = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2))
                                                : 13'($urandom_range(3, 12));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                h_val = 13'($urandom_range(0, 2));
            else if (pick == 1)
                h_val = 13'($urandom_range(4097, 8191));
            else
                h_val = 13'($urandom_range(3, 8));
            case ($urandom_range(0, 3))
                0: set_size(1'b1, w_val, 1'b1, h_val);
                1: set_size(1'b1, w_val, 1'b0, h_val);
                2: set_size(1'b0, w_val, 1'b1, h_val);
                default: drain_marks();
            endcase
            case ($urandom_range(0, 3))
                0: density = 15;
                1: density = 40;
                2: density = 70;
                default: density = 90;
            endcase
            seg_len = $urandom_range(10, 80);
            for (int i = 0; i < seg_len && sent < item_count; i++)
            begin
                send_pixel(random_pixel(density));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= 8'd0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= scm_pkg::REG_IMAGE_WIDTH;
        cfg_if.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_fill();
        test_window_cases();
        test_size_saturation();
        test_counter_wrap();
        test_random_frames(10, 82, 165);
        test_random_frames(82, 10, 165);
        test_random_frames(0, 0, 170);

        drain_marks();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results pending", $realtime, expected_marks.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/scm_pkg.sv
hdl/scm_pixel_if.sv
hdl/scm_result_if.sv
hdl/scm_cfg_if.sv
hdl/scm_ram.sv
hdl/shrink_conditional_mark_top.sv
hdl/scm_checker.sv
dv/tb.sv
